/* rtl/core/brdt_pkg.sv */
// brdt_pkg: shared constants, types and compact-word helpers for the retarget block
`timescale 1ns / 1ps
package brdt_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WORK_LIMIT     = 2'd0;
    localparam logic [1:0] REG_STAKE_LIMIT    = 2'd1;
    localparam logic [1:0] REG_STAKE_V2_LIMIT = 2'd2;

    // history codes
    localparam logic [1:0] HIST_FULL        = 2'd0;
    localparam logic [1:0] HIST_SHORT_CHAIN = 2'd1;

    localparam logic [31:0] LIMIT_RESET = 32'h1E0F_FFFF;
    // compact form of 2^256-1
    localparam logic [31:0] SAT_WORD    = 32'h2100_FFFF;

    // target spacing, spacing cap, (interval-1)*spacing and (interval+1)*spacing
    localparam logic [6:0]  SPACING_V1 = 7'd60;
    localparam logic [6:0]  SPACING_V2 = 7'd64;
    localparam logic [9:0]  CAP_V1     = 10'd600;
    localparam logic [9:0]  CAP_V2     = 10'd640;
    localparam logic [16:0] BASE_V1    = 17'd86340;
    localparam logic [16:0] BASE_V2    = 17'd86336;
    localparam logic [16:0] DIVISOR_V1 = 17'd86460;
    localparam logic [16:0] DIVISOR_V2 = 17'd86464;

    // long division datapath: 96-bit dividend, 8 quotient bits per stage
    localparam int WORK_W         = 96;
    localparam int BITS_PER_STAGE = 8;
    localparam int DIV_STAGES     = WORK_W / BITS_PER_STAGE;

    typedef struct packed {
        logic [22:0] mant;   // value of the low three bytes
        logic [7:0]  shift;  // byte offset of that value
        logic [1:0]  top;    // top nonzero byte within mant
        logic        zero;
        logic        ovf;    // needs more than 256 bits
    } dec_t;

    typedef struct packed {
        logic        force_limit;
        logic        lsat;
        logic        lzero;
        logic [8:0]  tl;         // top byte index of the limit
        logic [23:0] l3;         // top three bytes of the limit
        logic [31:0] lim_word;   // limit in compact form
        logic [7:0]  d;          // bytes shifted beyond the division
    } side_t;

    function automatic dec_t decode(input logic [31:0] bits);
        dec_t        r;
        logic [7:0]  size;
        logic [22:0] m;
        logic [8:0]  tpos;
        size = bits[31:24];
        m    = bits[22:0];
        case (size)
            8'd0:    r.mant = '0;
            8'd1:    r.mant = m >> 16;
            8'd2:    r.mant = m >> 8;
            default: r.mant = m;
        endcase
        r.shift = (size > 8'd3) ? size - 8'd3 : 8'd0;
        if (r.mant[22:16] != '0) begin
            r.top = 2'd2;
        end else if (r.mant[15:8] != '0) begin
            r.top = 2'd1;
        end else begin
            r.top = 2'd0;
        end
        r.zero = (r.mant == '0);
        tpos   = {1'b0, r.shift} + {7'd0, r.top};
        r.ovf  = !r.zero && (tpos >= 9'd32);
        return r;
    endfunction

    // top byte of the value moved to bits 23:16
    function automatic logic [23:0] norm3(input dec_t v);
        logic [23:0] r;
        case (v.top)
            2'd2:    r = {1'b0, v.mant};
            2'd1:    r = {v.mant[15:0], 8'h00};
            default: r = {v.mant[7:0], 16'h0000};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] encode(input logic [8:0] t, input logic [23:0] c);
        logic [8:0] sz;
        logic [31:0] r;
        if (c[23]) begin
            sz = t + 9'd2;
            r  = {sz[7:0], 8'h00, c[23:8]};
        end else begin
            sz = t + 9'd1;
            r  = {sz[7:0], c};
        end
        return r;
    endfunction

endpackage

/* rtl/core/brdt_divider.sv */
// brdt_divider: pipelined restoring division by the spacing-dependent constant
`timescale 1ns / 1ps
module brdt_divider
    import brdt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WORK_W-1:0] in_work,
    input  logic              in_v2,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [WORK_W-1:0] out_quo,
    output logic [16:0]       out_rem,
    output logic              out_v2,
    output side_t             out_side
);

    typedef struct packed {
        logic [16:0]       rem;
        logic [WORK_W-1:0] work;
    } step_t;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    function automatic step_t div_step(input logic [16:0] rem_in,
                                       input logic [WORK_W-1:0] work_in,
                                       input logic [16:0] dvs);
        step_t       r;
        logic [17:0] t;
        r.rem  = rem_in;
        r.work = work_in;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            t      = {r.rem, r.work[WORK_W-1]};
            r.work = {r.work[WORK_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                r.rem     = 17'(t - {1'b0, dvs});
                r.work[0] = 1'b1;
            end else begin
                r.rem = t[16:0];
            end
        end
        return r;
    endfunction

    logic              valid_reg [DIV_STAGES];
    logic [WORK_W-1:0] work_reg  [DIV_STAGES];
    logic [16:0]       rem_reg   [DIV_STAGES];
    logic              v2_reg    [DIV_STAGES];
    side_t             side_reg  [DIV_STAGES];

    genvar g;
    for (g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic              vin;
        logic [WORK_W-1:0] win;
        logic [16:0]       rin;
        logic              v2in;
        side_t             sin;
        step_t             stage_next;

        if (g == 0) begin : g_first
            assign vin  = in_valid;
            assign win  = in_work;
            assign rin  = '0;
            assign v2in = in_v2;
            assign sin  = in_side;
        end else begin : g_rest
            assign vin  = valid_reg[g-1];
            assign win  = work_reg[g-1];
            assign rin  = rem_reg[g-1];
            assign v2in = v2_reg[g-1];
            assign sin  = side_reg[g-1];
        end

        assign stage_next = div_step(rin, win, v2in ? DIVISOR_V2 : DIVISOR_V1);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[g] <= stage_next.work;
                rem_reg[g]  <= stage_next.rem;
                v2_reg[g]   <= v2in;
                side_reg[g] <= sin;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = work_reg[DIV_STAGES-1];
    assign out_rem   = rem_reg[DIV_STAGES-1];
    assign out_v2    = v2_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

    // the remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_rem < (out_v2 ? DIVISOR_V2 : DIVISOR_V1)))
        else $error("division remainder not below divisor");

endmodule

/* rtl/core/block_difficulty_retarget.sv */
// block_difficulty_retarget: compact target retarget, one word per cycle
// pipeline: 3 prep stages, 12 divide stages and 2 normalize/select stages; the first
//   stage loads at the accepting edge
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// reset: aresetn synchronous active low clears all valid bits and loads the three
//   limit registers with 0x1E0FFFFF
`timescale 1ns / 1ps
module block_difficulty_retarget
    import brdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_prev_bits,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_earlier_time,
    input  logic        s_stake_kind,
    input  logic        s_protocol_v2,
    input  logic        s_protocol_v3,
    input  logic [1:0]  s_history_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_bits
);

    logic [31:0] work_limit_reg;
    logic [31:0] stake_limit_reg;
    logic [31:0] stake_v2_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_limit_reg     <= LIMIT_RESET;
            stake_limit_reg    <= LIMIT_RESET;
            stake_v2_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WORK_LIMIT:     work_limit_reg     <= cfg_data;
                REG_STAKE_LIMIT:    stake_limit_reg    <= cfg_data;
                REG_STAKE_V2_LIMIT: stake_v2_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic        m_valid_reg;
    logic [31:0] m_next_bits_reg;

    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: decode, spacing, limit
    logic [31:0] lim_bits;
    dec_t        ld;
    dec_t        pd;
    logic [8:0]  tl_c;
    logic [23:0] l3_c;
    logic [32:0] diff;
    logic [31:0] act;
    logic [31:0] act_capped;
    logic [6:0]  spacing;
    logic [9:0]  cap;
    logic [16:0] base;
    logic [2:0]  f_c;
    side_t       side_c;

    always_comb begin
        if (s_history_code == HIST_SHORT_CHAIN) begin
            lim_bits = work_limit_reg;
        end else if (s_stake_kind) begin
            lim_bits = s_protocol_v2 ? stake_v2_limit_reg : stake_limit_reg;
        end else begin
            lim_bits = work_limit_reg;
        end
        ld   = decode(lim_bits);
        pd   = decode(s_prev_bits);
        tl_c = {1'b0, ld.shift} + {7'd0, ld.top};
        l3_c = norm3(ld);

        spacing = s_protocol_v2 ? SPACING_V2 : SPACING_V1;
        cap     = s_protocol_v2 ? CAP_V2 : CAP_V1;
        base    = s_protocol_v2 ? BASE_V2 : BASE_V1;
        diff    = {1'b0, s_last_time} - {1'b0, s_earlier_time};
        act     = diff[32] ? {25'd0, spacing} : diff[31:0];
        act_capped = (s_protocol_v3 && (act > {22'd0, cap})) ? {22'd0, cap} : act;

        f_c = (pd.shift > 8'd4) ? 3'd4 : pd.shift[2:0];

        side_c.force_limit = (s_history_code != HIST_FULL) || pd.ovf || pd.zero
                           || ((s_prev_bits[31:24] != 8'd0) && s_prev_bits[23]);
        side_c.lsat  = ld.ovf;
        side_c.lzero = ld.zero;
        side_c.tl    = tl_c;
        side_c.l3    = l3_c;
        if (ld.ovf) begin
            side_c.lim_word = SAT_WORD;
        end else if (ld.zero) begin
            side_c.lim_word = '0;
        end else begin
            side_c.lim_word = encode(tl_c, l3_c);
        end
        side_c.d = pd.shift - {5'd0, f_c};
    end

    logic        s1_valid_reg;
    logic [22:0] s1_mant_reg;
    logic [33:0] s1_mult_reg;
    logic [2:0]  s1_f_reg;
    logic        s1_v2_reg;
    side_t       s1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mant_reg <= pd.mant;
            s1_mult_reg <= {17'd0, base} + {1'b0, act_capped, 1'b0};
            s1_f_reg    <= f_c;
            s1_v2_reg   <= s_protocol_v2;
            s1_side_reg <= side_c;
        end
    end

    // stage 2: target mantissa times weighted spacing
    logic        s2_valid_reg;
    logic [56:0] s2_prod_reg;
    logic [2:0]  s2_f_reg;
    logic        s2_v2_reg;
    side_t       s2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_prod_reg <= {34'd0, s1_mant_reg} * {23'd0, s1_mult_reg};
            s2_f_reg    <= s1_f_reg;
            s2_v2_reg   <= s1_v2_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    // stage 3: up to four fraction bytes ahead of the division
    logic              s3_valid_reg;
    logic [WORK_W-1:0] s3_work_reg;
    logic              s3_v2_reg;
    side_t             s3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_work_reg <= {39'd0, s2_prod_reg} << {s2_f_reg, 3'b000};
            s3_v2_reg   <= s2_v2_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    logic              dv_valid;
    logic [WORK_W-1:0] dv_quo;
    logic [16:0]       dv_rem;
    logic              dv_v2;
    side_t             dv_side;

    brdt_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_work   (s3_work_reg),
        .in_v2     (s3_v2_reg),
        .in_side   (s3_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem),
        .out_v2    (dv_v2),
        .out_side  (dv_side)
    );

    // post stage 1: top byte, leading three bytes and sticky of the quotient
    logic [3:0]        tf;
    logic [WORK_W-1:0] fsh;
    logic [16:0]       dvs;
    logic              low_nz;

    always_comb begin
        tf = '0;
        for (int i = 0; i < WORK_W / 8; i++) begin
            if (dv_quo[8*i +: 8] != 8'h00) begin
                tf = 4'(i);
            end
        end
        fsh = dv_quo << {4'd11 - tf, 3'b000};
        dvs = dv_v2 ? DIVISOR_V2 : DIVISOR_V1;
        // bytes dropped below the division are nonzero when the remainder reaches them
        case (dv_side.d)
            8'd0:    low_nz = 1'b0;
            8'd1:    low_nz = {dv_rem, 8'h00} >= {8'h00, dvs};
            8'd2:    low_nz = {dv_rem, 16'h0000} >= {16'h0000, dvs};
            default: low_nz = (dv_rem != '0);
        endcase
    end

    logic        p1_valid_reg;
    logic [8:0]  p1_tq_reg;
    logic [23:0] p1_q3_reg;
    logic        p1_sticky_reg;
    logic        p1_fzero_reg;
    side_t       p1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_tq_reg     <= {5'd0, tf} + {1'b0, dv_side.d};
            p1_q3_reg     <= fsh[WORK_W-1 -: 24];
            p1_sticky_reg <= (fsh[WORK_W-25:0] != '0) || low_nz;
            p1_fzero_reg  <= (dv_quo == '0);
            p1_side_reg   <= dv_side;
        end
    end

    // post stage 2: compare with the limit and pick the word
    logic        greater;
    logic        use_limit;
    logic [31:0] word_next;

    always_comb begin
        if (p1_side_reg.lsat) begin
            greater = (p1_tq_reg >= 9'd32);
        end else if (p1_side_reg.lzero) begin
            greater = 1'b1;
        end else begin
            greater = (p1_tq_reg > p1_side_reg.tl)
                   || ((p1_tq_reg == p1_side_reg.tl)
                       && ((p1_q3_reg > p1_side_reg.l3)
                           || ((p1_q3_reg == p1_side_reg.l3) && p1_sticky_reg)));
        end
        use_limit = p1_side_reg.force_limit || p1_fzero_reg || greater;
        word_next = use_limit ? p1_side_reg.lim_word : encode(p1_tq_reg, p1_q3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_next_bits_reg <= word_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_next_bits = m_next_bits_reg;

    // input is held back only by a waiting output word
    a_ready_only_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting output word");

    // an accepted word always lands in the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted word lost at pipeline entry");

    // leading quotient bytes are normalized
    a_q3_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_fzero_reg) |-> (p1_q3_reg[23:16] != 8'h00))
        else $error("quotient leading byte not normalized");

endmodule

/* bench/block_difficulty_retarget_tb.sv */
// block_difficulty_retarget_tb: self-checking bench with a wide-integer retarget predictor
`timescale 1ns / 1ps
module block_difficulty_retarget_tb;
    import brdt_pkg::*;

    localparam logic [1:0] HIST_FEW_SAME = 2'd2;
    localparam logic [1:0] HIST_UNUSED   = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [31:0] prev_bits;
        logic [31:0] last_time;
        logic [31:0] earlier_time;
        logic        stake_kind;
        logic        protocol_v2;
        logic        protocol_v3;
        logic [1:0]  history_code;
    } retarget_req_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_prev_bits;
    logic [31:0] s_last_time;
    logic [31:0] s_earlier_time;
    logic        s_stake_kind;
    logic        s_protocol_v2;
    logic        s_protocol_v3;
    logic [1:0]  s_history_code;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_next_bits;

    block_difficulty_retarget dut (.*);

    retarget_req_t req_queue[$];
    logic [31:0]   bits_expected[$];
    logic [31:0]   work_lim, stake_lim, stake_v2_lim;
    bit            failed = 0;
    bit            burst_mode = 0;
    bit            long_hold_req = 0;
    int            idle_cycles = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // byte-wise view of a compact word on a 320-bit value
    function automatic logic [319:0] unpack_target(input logic [31:0] w,
                                                   output logic neg, output logic ovf);
        logic [319:0] v;
        logic [7:0]   sz;
        logic [23:0]  m;
        int           p;
        v = '0;
        sz = w[31:24];
        m = {1'b0, w[22:0]};
        neg = (sz >= 8'd1) && w[23];
        ovf = 1'b0;
        if (sz <= 8'd3) begin
            v[23:0] = m >> (8 * (3 - sz));
        end else begin
            for (int i = 0; i < 3; i++) begin
                p = int'(sz) - 3 + i;
                if (p < 40) v[p*8 +: 8] = m[i*8 +: 8];
                else if (m[i*8 +: 8] != 8'h00) ovf = 1'b1;
            end
        end
        if (v[319:256] != '0) ovf = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] pack_target(input logic [319:0] v);
        int          t;
        logic [31:0] c0, c1, c2;
        t = -1;
        for (int i = 39; i >= 0; i--) begin
            if (v[i*8 +: 8] != 8'h00) begin
                t = i;
                break;
            end
        end
        if (t < 0) return 32'h0;
        c0 = v[t*8 +: 8];
        c1 = (t >= 1) ? v[(t-1)*8 +: 8] : 8'h00;
        c2 = (t >= 2) ? v[(t-2)*8 +: 8] : 8'h00;
        if (c0[7]) return ((t + 2) << 24) | (c0 << 8) | c1;
        return ((t + 1) << 24) | (c0 << 16) | (c1 << 8) | c2;
    endfunction

    // limits ignore the sign and saturate past 256 bits
    function automatic logic [319:0] limit_value(input logic [31:0] w);
        logic [319:0] v;
        logic         neg, ovf;
        v = unpack_target(w, neg, ovf);
        if (ovf) v = {64'h0, {256{1'b1}}};
        return v;
    endfunction

    function automatic logic [31:0] next_target(input retarget_req_t r);
        logic [31:0]  kind_bits;
        logic [319:0] lim, val, mult_w, div_w, quot;
        logic         neg, ovf;
        longint       tsp, intv, act;
        kind_bits = r.stake_kind ? (r.protocol_v2 ? stake_v2_lim : stake_lim) : work_lim;
        if (r.history_code == HIST_SHORT_CHAIN) return pack_target(limit_value(work_lim));
        lim = limit_value(kind_bits);
        if (r.history_code != HIST_FULL) return pack_target(lim);
        tsp = r.protocol_v2 ? 64 : 60;
        intv = 86400 / tsp;
        act = longint'(r.last_time) - longint'(r.earlier_time);
        if (act < 0) act = tsp;
        if (r.protocol_v3 && act > tsp * 10) act = tsp * 10;
        mult_w = (intv - 1) * tsp + 2 * act;
        div_w = (intv + 1) * tsp;
        val = unpack_target(r.prev_bits, neg, ovf);
        if (ovf || neg || val == '0) return pack_target(lim);
        quot = (val * mult_w) / div_w;
        if (quot == '0 || quot > lim) return pack_target(lim);
        return pack_target(quot);
    endfunction

    function automatic logic [31:0] rand_compact();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0, 1: w[31:24] = 8'($urandom_range(1, 'h1f));
            2: w[31:24] = 8'($urandom_range('h1c, 'h22));
            3: begin
                w[31:24] = 8'($urandom_range(1, 'h20));
                w[23]    = 1'b0;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic retarget_req_t rand_req();
        retarget_req_t r;
        logic [31:0]   delta;
        r.prev_bits = rand_compact();
        r.earlier_time = $urandom;
        case ($urandom_range(0, 5))
            0: delta = -$urandom_range(1, 5000);
            1: delta = $urandom_range(0, 128);
            2: delta = $urandom_range(500, 800);
            3: delta = $urandom;
            default: delta = $urandom_range(0, 2000);
        endcase
        r.last_time = r.earlier_time + delta;
        r.stake_kind = 1'($urandom_range(0, 1));
        r.protocol_v2 = 1'($urandom_range(0, 1));
        r.protocol_v3 = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
            0: r.history_code = HIST_SHORT_CHAIN;
            1: r.history_code = HIST_FEW_SAME;
            2: r.history_code = HIST_UNUSED;
            default: r.history_code = HIST_FULL;
        endcase
        return r;
    endfunction

    function automatic retarget_req_t make_req(input logic [31:0] pb, input logic [31:0] lt,
                                               input logic [31:0] et, input logic [2:0] flags,
                                               input logic [1:0] hc);
        retarget_req_t r;
        r.prev_bits = pb;
        r.last_time = lt;
        r.earlier_time = et;
        {r.stake_kind, r.protocol_v2, r.protocol_v3} = flags;
        r.history_code = hc;
        return r;
    endfunction

    // sender
    retarget_req_t cur_req;
    int            send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready) bits_expected.push_back(next_target(cur_req));
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                cur_req = req_queue.pop_front();
                s_prev_bits    <= cur_req.prev_bits;
                s_last_time    <= cur_req.last_time;
                s_earlier_time <= cur_req.earlier_time;
                s_stake_kind   <= cur_req.stake_kind;
                s_protocol_v2  <= cur_req.protocol_v2;
                s_protocol_v3  <= cur_req.protocol_v3;
                s_history_code <= cur_req.history_code;
                s_valid <= 1'b1;
                if (!burst_mode && $urandom_range(0, 2) == 0)
                    send_gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(1, 3);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and result check
    int recv_stall = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (bits_expected.size() == 0) begin
                    $error("unexpected word next_bits=%h", m_next_bits);
                    failed = 1;
                end else begin
                    logic [31:0] want;
                    want = bits_expected.pop_front();
                    if (m_next_bits !== want) begin
                        $error("next_bits expected %h actual %h", want, m_next_bits);
                        failed = 1;
                    end
                end
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                recv_stall = 400;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!burst_mode && $urandom_range(0, 3) == 0)
                    recv_stall = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    // watchdog on stalled progress while work is outstanding
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)
                || (req_queue.size() == 0 && bits_expected.size() == 0 && !s_valid))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        case (idx)
            REG_WORK_LIMIT:  work_lim = value;
            REG_STAKE_LIMIT: stake_lim = value;
            default:         stake_v2_lim = value;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_all();
        while (req_queue.size() > 0 || s_valid || bits_expected.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    logic [31:0] limit_sets[7][3];
    initial begin
        limit_sets[0] = '{LIMIT_RESET, LIMIT_RESET, LIMIT_RESET};
        limit_sets[1] = '{32'h0000_0000, 32'hFFFF_FFFF, SAT_WORD};
        limit_sets[2] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h1D00_FFFF};
        limit_sets[3] = '{32'h1E8F_FFFF, 32'h0300_0001, 32'h0000_0000};
        limit_sets[4] = '{32'h2100_0001, 32'h2200_FFFF, 32'hFFFF_FFFF};
        limit_sets[5] = '{32'h1D00_FFFF, 32'h1C7F_FFFF, 32'h0412_3456};
        limit_sets[6] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    end

    initial begin
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_addr = REG_WORK_LIMIT;
        cfg_data = '0;
        s_valid = 0;
        s_prev_bits = '0;
        s_last_time = '0;
        s_earlier_time = '0;
        s_stake_kind = 0;
        s_protocol_v2 = 0;
        s_protocol_v3 = 0;
        s_history_code = HIST_FULL;
        m_ready = 0;
        work_lim = LIMIT_RESET;
        stake_lim = LIMIT_RESET;
        stake_v2_lim = LIMIT_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners under reset limits
        req_queue.push_back(make_req(32'h0000_0000, 1000, 900, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h0080_0000, 1000, 900, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h0180_0001, 1000, 900, 3'b100, HIST_FULL));
        req_queue.push_back(make_req(32'hFFFF_FFFF, 1000, 900, 3'b010, HIST_FULL));
        req_queue.push_back(make_req(32'h2101_0000, 1000, 900, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h2000_FFFF, 1000, 900, 3'b001, HIST_FULL));
        req_queue.push_back(make_req(32'h1D00_FFFF, 1060, 1000, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h1D00_FFFF, 1000, 1060, 3'b110, HIST_FULL));
        req_queue.push_back(make_req(32'h1C7F_FFFF, 32'hFFFF_FFFF, 0, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h1C7F_FFFF, 32'hFFFF_FFFF, 0, 3'b001, HIST_FULL));
        req_queue.push_back(make_req(32'h1C7F_FFFF, 32'hFFFF_FFFF, 0, 3'b011, HIST_FULL));
        req_queue.push_back(make_req(32'h0, 0, 32'hFFFF_FFFF, 3'b111, HIST_FULL));
        req_queue.push_back(make_req(32'h0101_0000, 0, 0, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h0103_0000, 0, 0, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h0212_3400, 500, 400, 3'b100, HIST_FULL));
        req_queue.push_back(make_req(32'h0312_3456, 500, 400, 3'b000, HIST_FULL));
        req_queue.push_back(make_req(32'h047F_FFFF, 640, 0, 3'b101, HIST_FULL));
        req_queue.push_back(make_req(32'h1B04_0000, 0, 0, 3'b100, HIST_SHORT_CHAIN));
        req_queue.push_back(make_req(32'h1B04_0000, 0, 0, 3'b110, HIST_FEW_SAME));
        req_queue.push_back(make_req(32'h1B04_0000, 0, 0, 3'b100, HIST_FEW_SAME));
        req_queue.push_back(make_req(32'h1B04_0000, 0, 0, 3'b000, HIST_UNUSED));
        req_queue.push_back(make_req(32'h1B04_0000, 0, 0, 3'b110, HIST_UNUSED));
        drain_all();

        for (int ph = 0; ph < 7; ph++) begin
            write_limit(REG_WORK_LIMIT, (ph == 6) ? $urandom : limit_sets[ph][0]);
            write_limit(REG_STAKE_LIMIT, (ph == 6) ? $urandom : limit_sets[ph][1]);
            write_limit(REG_STAKE_V2_LIMIT, (ph == 6) ? rand_compact() : limit_sets[ph][2]);
            burst_mode = (ph == 3);
            if (ph == 1) long_hold_req = 1;
            for (int n = 0; n < 148; n++) req_queue.push_back(rand_req());
            // the bench waits until every word of this batch is checked before the next one
            drain_all();
        end
        burst_mode = 0;

        if (failed || bits_expected.size() != 0)
            $display("TEST FAILED");
        else
            $display("TEST PASSED");
        $finish;
    end
endmodule

/* block_difficulty_retarget.f */
rtl/core/brdt_pkg.sv
rtl/core/brdt_divider.sv
rtl/core/block_difficulty_retarget.sv
bench/block_difficulty_retarget_tb.sv
